>>> hw/rtl/esrc_pkg.sv
// Shared types, constants and arithmetic helpers of the sensor compensation unit.
package esrc_pkg;

   localparam int FRONT_DEPTH = 12;
   localparam int DIV_DEPTH   = 32;
   localparam int POST_DEPTH  = 3;
   localparam int LATENCY     = FRONT_DEPTH + DIV_DEPTH + POST_DEPTH;

   localparam logic [31:0] PRESS_OFFSET = 32'd64000;
   localparam logic [31:0] PRESS_FULL   = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE  = 32'd3125;
   localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
   localparam logic [31:0] HUM_OFFSET   = 32'd76800;
   localparam logic [31:0] HUM_LIMIT    = 32'd419430400;
   localparam logic [31:0] HUM_BIAS     = 32'd2097152;
   localparam logic [31:0] UNITY_Q15    = 32'd32768;
   localparam logic [31:0] ROUND_Q15    = 32'd16384;
   localparam logic [31:0] ROUND_Q14    = 32'd8192;
   localparam logic [31:0] TEMP_ROUND   = 32'd128;
   localparam logic [16:0] HUM_MAX      = 17'd102400;

   typedef enum logic [2:0] {
      CSR_TEMP       = 3'd0,
      CSR_PRESS_LOW  = 3'd1,
      CSR_PRESS_HIGH = 3'd2,
      CSR_MIXED      = 3'd3,
      CSR_HUM        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature;
      logic [31:0]        pressure;
      logic [16:0]        humidity;
   } rsp_type;

   // All coefficients, already extended to 32 bits.
   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } coeff_type;

   // Results that ride alongside the divider.
   typedef struct packed {
      logic [31:0] temperature;
      logic [16:0] humidity;
      logic        zero;
      logic        shift_q;
   } side_type;

   typedef struct packed {
      logic [31:0] dividend;
      logic [31:0] divisor;
      side_type    side;
   } front_type;

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return p[31:0];
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic coeff_type decode_coeffs(input logic [47:0] tc, input logic [63:0] pl,
                                              input logic [63:0] ph, input logic [47:0] mc,
                                              input logic [31:0] hc);
      coeff_type c;
      c.t1 = 32'(tc[15:0]);
      c.t2 = 32'($signed(tc[31:16]));
      c.t3 = 32'($signed(tc[47:32]));
      c.p1 = 32'(pl[15:0]);
      c.p2 = 32'($signed(pl[31:16]));
      c.p3 = 32'($signed(pl[47:32]));
      c.p4 = 32'($signed(pl[63:48]));
      c.p5 = 32'($signed(ph[15:0]));
      c.p6 = 32'($signed(ph[31:16]));
      c.p7 = 32'($signed(ph[47:32]));
      c.p8 = 32'($signed(ph[63:48]));
      c.p9 = 32'($signed(mc[15:0]));
      c.h1 = 32'(mc[23:16]);
      c.h2 = 32'($signed(mc[39:24]));
      c.h3 = 32'(mc[47:40]);
      c.h4 = 32'($signed(hc[11:0]));
      c.h5 = 32'($signed(hc[23:12]));
      c.h6 = 32'($signed(hc[31:24]));
      return c;
   endfunction

endpackage

>>> hw/rtl/esrc_front.sv
// Front pipeline: temperature, humidity and the pressure dividend and divisor.
module esrc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  esrc_pkg::req_type   in_data,
   input  esrc_pkg::coeff_type coeff,
   output logic               out_valid,
   output esrc_pkg::front_type out_data
);
   import esrc_pkg::*;

   logic [FRONT_DEPTH:1] vld_ff;

   logic [31:0] at32, dt;
   logic [31:0] ma1_ff, md1_ff;
   logic [19:0] ap1_ff, ap2_ff, ap3_ff, ap4_ff, ap5_ff, ap6_ff, ap7_ff;
   logic [15:0] ah1_ff, ah2_ff, ah3_ff, ah4_ff, ah5_ff;
   logic [31:0] at2_ff, mb2_ff;
   logic [31:0] fine3_ff;
   logic [31:0] temp4_ff, temp5_ff, temp6_ff, temp7_ff, temp8_ff, temp9_ff;
   logic [31:0] temp10_ff, temp11_ff;
   logic [31:0] pa4_ff, hx4_ff, q4;
   logic [31:0] qq5_ff, m55_ff, m25_ff, hh5_ff, hg6_ff, hg3_ff;
   logic [31:0] b66_ff, m36_ff, m56_ff, m26_ff, hu6_ff, hvi6_ff;
   logic [31:0] pb7_ff, pa7_ff, hvj7_ff, hu7_ff;
   logic [31:0] a38_ff, nb8_ff, hv8_ff, hu8_ff;
   logic [31:0] dv9_ff, pn9_ff, hxm9_ff;
   logic [31:0] dvd10_ff, dvs10_ff, sq10_ff, hxm10_ff, hw9;
   logic        zero10_ff, shq10_ff;
   logic [31:0] dvd11_ff, dvs11_ff, sqh11_ff, hxm11_ff;
   logic        zero11_ff, shq11_ff;
   logic [31:0] hd, hc;
   front_type   out_ff;

   assign at32 = 32'(in_data.raw_temperature);
   assign dt   = (at32 >> 4) - coeff.t1;
   assign q4   = asr(pa4_ff, 2);
   assign hw9  = asr(hxm9_ff, 15);

   // Final humidity correction, then clamp the value into its legal range.
   always_comb begin
      hd = hxm11_ff - asr(sqh11_ff, 4);
      if (hd[31]) begin
         hc = '0;
      end else if (hd > HUM_LIMIT) begin
         hc = HUM_LIMIT;
      end else begin
         hc = hd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_DEPTH-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      // Fine temperature.
      ma1_ff   <= mul32((at32 >> 3) - (coeff.t1 << 1), coeff.t2);
      md1_ff   <= mul32(dt, dt);
      ap1_ff   <= in_data.raw_pressure;
      ah1_ff   <= in_data.raw_humidity;
      at2_ff   <= asr(ma1_ff, 11);
      mb2_ff   <= mul32(asr(md1_ff, 12), coeff.t3);
      ap2_ff   <= ap1_ff;
      ah2_ff   <= ah1_ff;
      fine3_ff <= at2_ff + asr(mb2_ff, 14);
      ap3_ff   <= ap2_ff;
      ah3_ff   <= ah2_ff;
      temp4_ff <= asr((fine3_ff << 2) + fine3_ff + TEMP_ROUND, 8);
      pa4_ff   <= asr(fine3_ff, 1) - PRESS_OFFSET;
      hx4_ff   <= fine3_ff - HUM_OFFSET;
      ap4_ff   <= ap3_ff;
      ah4_ff   <= ah3_ff;
      // Pressure and humidity products.
      qq5_ff   <= mul32(q4, q4);
      m55_ff   <= mul32(pa4_ff, coeff.p5);
      m25_ff   <= mul32(coeff.p2, pa4_ff);
      hh5_ff   <= mul32(coeff.h5, hx4_ff);
      hg6_ff   <= mul32(hx4_ff, coeff.h6);
      hg3_ff   <= mul32(hx4_ff, coeff.h3);
      temp5_ff <= temp4_ff;
      ap5_ff   <= ap4_ff;
      ah5_ff   <= ah4_ff;
      b66_ff   <= mul32(asr(qq5_ff, 11), coeff.p6);
      m36_ff   <= mul32(coeff.p3, asr(qq5_ff, 13));
      m56_ff   <= m55_ff;
      m26_ff   <= m25_ff;
      hu6_ff   <= asr((32'(ah5_ff) << 14) - (coeff.h4 << 20) - hh5_ff + ROUND_Q15, 15);
      hvi6_ff  <= mul32(asr(hg6_ff, 10), asr(hg3_ff, 11) + UNITY_Q15);
      temp6_ff <= temp5_ff;
      ap6_ff   <= ap5_ff;
      pb7_ff   <= asr(b66_ff + (m56_ff << 1), 2) + (coeff.p4 << 16);
      pa7_ff   <= asr(asr(m36_ff, 3) + asr(m26_ff, 1), 18);
      hvj7_ff  <= mul32(asr(hvi6_ff, 10) + HUM_BIAS, coeff.h2);
      hu7_ff   <= hu6_ff;
      temp7_ff <= temp6_ff;
      ap7_ff   <= ap6_ff;
      a38_ff   <= mul32(UNITY_Q15 + pa7_ff, coeff.p1);
      nb8_ff   <= (PRESS_FULL - 32'(ap7_ff)) - asr(pb7_ff, 12);
      hv8_ff   <= asr(hvj7_ff + ROUND_Q14, 14);
      hu8_ff   <= hu7_ff;
      temp8_ff <= temp7_ff;
      dv9_ff   <= asr(a38_ff, 15);
      pn9_ff   <= mul32(nb8_ff, PRESS_SCALE);
      hxm9_ff  <= mul32(hu8_ff, hv8_ff);
      temp9_ff <= temp8_ff;
      // A numerator with its top bit set is divided first and doubled after.
      dvd10_ff  <= ((pn9_ff & SIGN_BIT) != '0) ? pn9_ff : (pn9_ff << 1);
      shq10_ff  <= (pn9_ff & SIGN_BIT) != '0;
      dvs10_ff  <= dv9_ff;
      zero10_ff <= dv9_ff == '0;
      sq10_ff   <= mul32(hw9, hw9);
      hxm10_ff  <= hxm9_ff;
      temp10_ff <= temp9_ff;
      sqh11_ff  <= mul32(asr(sq10_ff, 7), coeff.h1);
      hxm11_ff  <= hxm10_ff;
      dvd11_ff  <= dvd10_ff;
      dvs11_ff  <= dvs10_ff;
      zero11_ff <= zero10_ff;
      shq11_ff  <= shq10_ff;
      temp11_ff <= temp10_ff;
      out_ff.dividend         <= dvd11_ff;
      out_ff.divisor          <= dvs11_ff;
      out_ff.side.temperature <= temp11_ff;
      out_ff.side.humidity    <= 17'(hc >> 12);
      out_ff.side.zero        <= zero11_ff;
      out_ff.side.shift_q     <= shq11_ff;
   end

   assign out_valid = vld_ff[FRONT_DEPTH];
   assign out_data  = out_ff;

`ifndef ASSERT_OFF
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FRONT_DEPTH] |-> out_ff.side.humidity <= HUM_MAX)
      else $error("humidity beyond clamp limit");
`endif

endmodule

>>> hw/rtl/esrc_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module esrc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_dividend,
   input  logic [31:0]        in_divisor,
   input  esrc_pkg::side_type in_side,
   output logic               out_valid,
   output logic [31:0]        out_quotient,
   output esrc_pkg::side_type out_side
);
   import esrc_pkg::*;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dq;
   } dstep_type;

   // The dividend shifts out of dq at the top while quotient bits enter at the bottom.
   function automatic dstep_type div_step(input dstep_type s, input logic [31:0] dvs);
      dstep_type   n;
      logic [32:0] r;
      logic        ge;
      r  = {s.rem, s.dq[31]};
      ge = r >= {1'b0, dvs};
      n.rem = ge ? 32'(r - {1'b0, dvs}) : r[31:0];
      n.dq  = {s.dq[30:0], ge};
      return n;
   endfunction

   logic [DIV_DEPTH-1:0] vld_ff;
   dstep_type            st_ff   [DIV_DEPTH];
   logic [31:0]          dvs_ff  [DIV_DEPTH];
   side_type             side_ff [DIV_DEPTH];
   dstep_type            st_init;

   assign st_init.rem = '0;
   assign st_init.dq  = in_dividend;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_DEPTH-2:0], in_valid};
      end
   end

   for (genvar g = 0; g < DIV_DEPTH; g++) begin : g_stage
      if (g == 0) begin : g_first
         always_ff @(posedge clock) begin
            st_ff[g]   <= div_step(st_init, in_divisor);
            dvs_ff[g]  <= in_divisor;
            side_ff[g] <= in_side;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            st_ff[g]   <= div_step(st_ff[g-1], dvs_ff[g-1]);
            dvs_ff[g]  <= dvs_ff[g-1];
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   assign out_valid    = vld_ff[DIV_DEPTH-1];
   assign out_quotient = st_ff[DIV_DEPTH-1].dq;
   assign out_side     = side_ff[DIV_DEPTH-1];

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DIV_DEPTH-1] && dvs_ff[DIV_DEPTH-1] != '0) |->
         st_ff[DIV_DEPTH-1].rem < dvs_ff[DIV_DEPTH-1])
      else $error("divider remainder not below divisor");
`endif

endmodule

>>> hw/rtl/esrc_post.sv
// Pressure correction after the division and the result register.
module esrc_post (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_quotient,
   input  esrc_pkg::side_type in_side,
   input  esrc_pkg::coeff_type coeff,
   output logic               out_valid,
   output esrc_pkg::rsp_type   out_data
);
   import esrc_pkg::*;

   logic [POST_DEPTH:1] vld_ff;
   logic [31:0] p0;
   logic [31:0] p1_ff, ss1_ff, c2m1_ff;
   logic [31:0] p2_ff, c1m2_ff, c2m2_ff;
   side_type    side1_ff, side2_ff;
   rsp_type     rsp_ff;

   assign p0 = in_side.shift_q ? (in_quotient << 1) : in_quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[POST_DEPTH-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      p1_ff    <= p0;
      ss1_ff   <= mul32(p0 >> 3, p0 >> 3);
      c2m1_ff  <= mul32(p0 >> 2, coeff.p8);
      side1_ff <= in_side;
      c1m2_ff  <= mul32(coeff.p9, ss1_ff >> 13);
      c2m2_ff  <= c2m1_ff;
      p2_ff    <= p1_ff;
      side2_ff <= side1_ff;
      rsp_ff.temperature <= side2_ff.temperature;
      rsp_ff.humidity    <= side2_ff.humidity;
      rsp_ff.pressure    <= side2_ff.zero ? '0 :
         p2_ff + asr(asr(c1m2_ff, 12) + asr(c2m2_ff, 13) + coeff.p7, 4);
   end

   assign out_valid = vld_ff[POST_DEPTH];
   assign out_data  = rsp_ff;

endmodule

>>> hw/rtl/env_sensor_raw_compensation_unit.sv
// Top level of the environmental sensor compensation unit.
// Takes one raw temperature/pressure/humidity beat per cycle whenever start is
// high (busy is always low) and returns the compensated beat on rsp_data with a
// one-cycle rsp_valid strobe after the front arithmetic, the pressure divider
// that yields the 32 quotient bits, and the pressure correction.
// Results come out in order and must be taken when strobed. Coefficients
// are written through the csr_ port by the user only while no beat is in
// flight, which the block does not enforce; each write takes effect at once.
module env_sensor_raw_compensation_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  esrc_pkg::req_type  req_data,
   output logic              rsp_valid,
   output esrc_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data
);
   import esrc_pkg::*;

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_coeffs_low_ff;
   logic [63:0] press_coeffs_high_ff;
   logic [47:0] mixed_coeffs_ff;
   logic [31:0] hum_coeffs_ff;
   coeff_type   coeff;
   logic        accept;
   logic        front_valid, div_valid;
   front_type   front_data;
   logic [31:0] quotient;
   side_type    div_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff       <= '0;
         press_coeffs_low_ff  <= '0;
         press_coeffs_high_ff <= '0;
         mixed_coeffs_ff      <= '0;
         hum_coeffs_ff        <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP:       temp_coeffs_ff       <= csr_data[47:0];
            CSR_PRESS_LOW:  press_coeffs_low_ff  <= csr_data;
            CSR_PRESS_HIGH: press_coeffs_high_ff <= csr_data;
            CSR_MIXED:      mixed_coeffs_ff      <= csr_data[47:0];
            CSR_HUM:        hum_coeffs_ff        <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   assign coeff  = decode_coeffs(temp_coeffs_ff, press_coeffs_low_ff, press_coeffs_high_ff,
                                 mixed_coeffs_ff, hum_coeffs_ff);
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   esrc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .coeff    (coeff),
      .out_valid(front_valid),
      .out_data (front_data)
   );

   esrc_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (front_valid),
      .in_dividend (front_data.dividend),
      .in_divisor  (front_data.divisor),
      .in_side     (front_data.side),
      .out_valid   (div_valid),
      .out_quotient(quotient),
      .out_side    (div_side)
   );

   esrc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_quotient(quotient),
      .in_side    (div_side),
      .coeff      (coeff),
      .out_valid  (rsp_valid),
      .out_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   a_strobe_follows_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without a matching accepted beat");
`endif

endmodule

>>> bench/env_sensor_raw_compensation_unit_tb.sv
// Self-checking testbench of the environmental sensor compensation unit.
`timescale 1ns / 100ps

module env_sensor_raw_compensation_unit_tb;
   import esrc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // Local copy of the coefficient registers.
   logic [47:0] temp_word;
   logic [63:0] press_lo_word, press_hi_word;
   logic [47:0] mixed_word;
   logic [31:0] hum_word;

   rsp_type     pending_results[$];
   int          error_count = 0;
   int          cycle_count = 0;

   env_sensor_raw_compensation_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] wmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return p[31:0];
   endfunction

   function automatic logic [31:0] sra(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic rsp_type compensate(req_type r);
      rsp_type     o;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] at, ap, ah, a, b, d, q, fine, p, s, c1, c2, x, u, v, w, sq;
      t1 = {16'd0, temp_word[15:0]};
      t2 = sx16(temp_word[31:16]);
      t3 = sx16(temp_word[47:32]);
      p1 = {16'd0, press_lo_word[15:0]};
      p2 = sx16(press_lo_word[31:16]);
      p3 = sx16(press_lo_word[47:32]);
      p4 = sx16(press_lo_word[63:48]);
      p5 = sx16(press_hi_word[15:0]);
      p6 = sx16(press_hi_word[31:16]);
      p7 = sx16(press_hi_word[47:32]);
      p8 = sx16(press_hi_word[63:48]);
      p9 = sx16(mixed_word[15:0]);
      h1 = {24'd0, mixed_word[23:16]};
      h2 = sx16(mixed_word[39:24]);
      h3 = {24'd0, mixed_word[47:40]};
      h4 = {{20{hum_word[11]}}, hum_word[11:0]};
      h5 = {{20{hum_word[23]}}, hum_word[23:12]};
      h6 = {{24{hum_word[31]}}, hum_word[31:24]};
      at = {12'd0, r.raw_temperature};
      ap = {12'd0, r.raw_pressure};
      ah = {16'd0, r.raw_humidity};

      a = sra(wmul((at >> 3) - (t1 << 1), t2), 11);
      d = (at >> 4) - t1;
      b = sra(wmul(sra(wmul(d, d), 12), t3), 14);
      fine = a + b;
      o.temperature = sra(wmul(fine, 32'd5) + 32'd128, 8);

      a = sra(fine, 1) - 32'd64000;
      q = sra(a, 2);
      b = wmul(sra(wmul(q, q), 11), p6);
      b = b + (wmul(a, p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(wmul(p3, sra(wmul(q, q), 13)), 3) + sra(wmul(p2, a), 1), 18);
      a = sra(wmul(32'd32768 + a, p1), 15);
      if (a == 32'd0) begin
         o.pressure = 32'd0;
      end else begin
         p = wmul((32'd1048576 - ap) - sra(b, 12), 32'd3125);
         if (p < 32'h8000_0000) p = (p << 1) / a;
         else p = (p / a) << 1;
         s = p >> 3;
         c1 = sra(wmul(p9, wmul(s, s) >> 13), 12);
         c2 = sra(wmul(p >> 2, p8), 13);
         o.pressure = p + sra(c1 + c2 + p7, 4);
      end

      x = fine - 32'd76800;
      u = sra((ah << 14) - (h4 << 20) - wmul(h5, x) + 32'd16384, 15);
      v = sra(wmul(sra(wmul(sra(wmul(x, h6), 10), sra(wmul(x, h3), 11) + 32'd32768), 10)
                   + 32'd2097152, h2) + 32'd8192, 14);
      x = wmul(u, v);
      w = sra(x, 15);
      sq = sra(wmul(w, w), 7);
      x = x - sra(wmul(sq, h1), 4);
      if (x[31]) x = 32'd0;
      if (x > 32'd419430400) x = 32'd419430400;
      o.humidity = x[28:12];
      return o;
   endfunction

   // Checks every strobed result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = pending_results.pop_front();
            if (rsp_data.temperature !== exp_rsp.temperature) begin
               $display("%0t: temperature expected %0d actual %0d", $time,
                        exp_rsp.temperature, rsp_data.temperature);
               error_count++;
            end
            if (rsp_data.pressure !== exp_rsp.pressure) begin
               $display("%0t: pressure expected %0d actual %0d", $time,
                        exp_rsp.pressure, rsp_data.pressure);
               error_count++;
            end
            if (rsp_data.humidity !== exp_rsp.humidity) begin
               $display("%0t: humidity expected %0d actual %0d", $time,
                        exp_rsp.humidity, rsp_data.humidity);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("env_sensor_raw_compensation_unit_tb: done, errors");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_TEMP:       temp_word     = value[47:0];
         CSR_PRESS_LOW:  press_lo_word = value;
         CSR_PRESS_HIGH: press_hi_word = value;
         CSR_MIXED:      mixed_word    = value[47:0];
         CSR_HUM:        hum_word      = value[31:0];
         default: ;
      endcase
   endtask

   // Drives one beat; start is held across back-to-back beats.
   task automatic send_sample(req_type r, bit gaps);
      int wait_cycles;
      wait_cycles = gaps ? $urandom_range(0, 7) : 0;
      if (wait_cycles > 0) begin
         start <= 1'b0;
         repeat (wait_cycles) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_results.push_back(compensate(r));
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic req_type random_sample();
      req_type r;
      r.raw_temperature = 20'($urandom);
      r.raw_pressure    = 20'($urandom);
      r.raw_humidity    = 16'($urandom);
      return r;
   endfunction

   // Coefficients near typical factory values with random perturbation.
   task automatic load_typical();
      write_csr(CSR_TEMP, 64'({16'(16'sd50 + 16'($urandom_range(0, 60)) - 16'd30),
                               16'(16'd26000 + 16'($urandom_range(0, 2000))),
                               16'(16'd27500 + 16'($urandom_range(0, 2000)))}));
      write_csr(CSR_PRESS_LOW, {16'(16'd8000 + 16'($urandom_range(0, 1000))),
                                16'(16'd3000 + 16'($urandom_range(0, 1000))),
                                16'(-16'sd10600 + 16'($urandom_range(0, 200))),
                                16'(16'd36000 + 16'($urandom_range(0, 2000)))});
      write_csr(CSR_PRESS_HIGH, {16'(-16'sd12000 + 16'($urandom_range(0, 200))),
                                 16'(16'd15000 + 16'($urandom_range(0, 200))),
                                 16'(-16'sd7),
                                 16'(-16'sd50 + 16'($urandom_range(0, 100)))});
      write_csr(CSR_MIXED, 64'({8'(8'd0), 16'(16'd360 + 16'($urandom_range(0, 20))),
                                8'(8'd75), 16'(16'd6000)}));
      write_csr(CSR_HUM, 64'({8'd30, 12'd50, 12'd320}));
   endtask

   task automatic load_random();
      write_csr(CSR_TEMP, {$urandom, $urandom});
      write_csr(CSR_PRESS_LOW, {$urandom, $urandom});
      write_csr(CSR_PRESS_HIGH, {$urandom, $urandom});
      write_csr(CSR_MIXED, {$urandom, $urandom});
      write_csr(CSR_HUM, {$urandom, $urandom});
   endtask

   // Field extremes under reset coefficients, where the divisor is zero.
   task automatic test_zero_divisor();
      send_sample('{20'h0, 20'h0, 16'h0}, 1'b0);
      send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b0);
      send_sample('{20'h80000, 20'h7FFFF, 16'h8000}, 1'b1);
      drain();
   endtask

   task automatic test_extreme_coeffs();
      write_csr(CSR_TEMP, '1);
      write_csr(CSR_PRESS_LOW, '1);
      write_csr(CSR_PRESS_HIGH, '1);
      write_csr(CSR_MIXED, '1);
      write_csr(CSR_HUM, '1);
      write_csr(csr_index_type'(3'd7), 64'h1234);
      send_sample('{20'hFFFFF, 20'h0, 16'hFFFF}, 1'b0);
      send_sample('{20'h0, 20'hFFFFF, 16'h0}, 1'b0);
      send_sample('{20'h55555, 20'hAAAAA, 16'h5555}, 1'b1);
      drain();
      write_csr(CSR_TEMP, 64'h8000_8000_0000);
      write_csr(CSR_PRESS_LOW, 64'h8000_8000_8000_FFFF);
      write_csr(CSR_PRESS_HIGH, 64'h8000_8000_8000_8000);
      write_csr(CSR_MIXED, 64'hFF_8000_FF_8000);
      write_csr(CSR_HUM, 64'h80_800_800);
      send_sample('{20'hAAAAA, 20'h55555, 16'hAAAA}, 1'b0);
      send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b1);
      drain();
   endtask

   // Typical coefficients: humidity reaches both clamps with extreme readings.
   task automatic test_typical(int count);
      load_typical();
      send_sample('{20'd519888, 20'd415148, 16'h0}, 1'b0);
      send_sample('{20'd519888, 20'd415148, 16'hFFFF}, 1'b0);
      for (int i = 0; i < count; i++) send_sample(random_sample(), $urandom_range(0, 3) != 0);
      drain();
   endtask

   task automatic test_random_coeffs(int count);
      load_random();
      for (int i = 0; i < count; i++) send_sample(random_sample(), $urandom_range(0, 1) != 0);
      drain();
   endtask

   initial begin
      temp_word = '0; press_lo_word = '0; press_hi_word = '0;
      mixed_word = '0; hum_word = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_zero_divisor();
      test_extreme_coeffs();
      for (int k = 0; k < 4; k++) test_typical(200);
      for (int k = 0; k < 6; k++) test_random_coeffs(100);
      if (error_count == 0) $display("env_sensor_raw_compensation_unit_tb: done, clean");
      else $display("env_sensor_raw_compensation_unit_tb: done, errors");
      $finish;
   end

endmodule
